// ===== src/dhcsp_pkg.sv =====
// Shared types and constants for the debounced hue classifier and sort pulse block.
package dhcsp_pkg;

    localparam int HUE_W     = 9;
    localparam int COLOR_W   = 2;
    localparam int CONFIRM_W = 10;
    localparam int SORT_W    = 16;
    localparam int TICK_W    = 7;
    localparam int DWELL_W   = 11;
    localparam int IDX_W     = 3;
    localparam int DATA_W    = 16;

    localparam logic [COLOR_W-1:0] COLOR_NONE = 2'd0;
    localparam logic [COLOR_W-1:0] COLOR_RED  = 2'd1;
    localparam logic [COLOR_W-1:0] COLOR_BLUE = 2'd2;

    localparam logic [IDX_W-1:0] REG_ALLIANCE  = 3'd0;
    localparam logic [IDX_W-1:0] REG_CONFIRM   = 3'd1;
    localparam logic [IDX_W-1:0] REG_SORT_TIME = 3'd2;
    localparam logic [IDX_W-1:0] REG_TICK_MS   = 3'd3;
    localparam logic [IDX_W-1:0] REG_BLUE_LOW  = 3'd4;
    localparam logic [IDX_W-1:0] REG_BLUE_HIGH = 3'd5;
    localparam logic [IDX_W-1:0] REG_RED_HIGH  = 3'd6;

    localparam logic [COLOR_W-1:0]   RST_ALLIANCE  = COLOR_NONE;
    localparam logic [CONFIRM_W-1:0] RST_CONFIRM   = 10'd50;
    localparam logic [SORT_W-1:0]    RST_SORT_TIME = 16'd1000;
    localparam logic [TICK_W-1:0]    RST_TICK_MS   = 7'd10;
    localparam logic [HUE_W-1:0]     RST_BLUE_LOW  = 9'd200;
    localparam logic [HUE_W-1:0]     RST_BLUE_HIGH = 9'd250;
    localparam logic [HUE_W-1:0]     RST_RED_HIGH  = 9'd20;

    typedef struct packed {
        logic [COLOR_W-1:0]   alliance_color;
        logic [CONFIRM_W-1:0] confirm_time;
        logic [SORT_W-1:0]    sort_time;
        logic [TICK_W-1:0]    tick_ms;
        logic [HUE_W-1:0]     blue_hue_low;
        logic [HUE_W-1:0]     blue_hue_high;
        logic [HUE_W-1:0]     red_hue_high;
    } cfg_t;

endpackage

// ===== src/dhcsp_cfg.sv =====
// Configuration register file for the hue classifier.
module dhcsp_cfg
    import dhcsp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [DATA_W-1:0] cfg_data,
    output logic              cfg_ready,
    output cfg_t              cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_ALLIANCE:  cfg_next.alliance_color = cfg_data[COLOR_W-1:0];
                REG_CONFIRM:   cfg_next.confirm_time   = cfg_data[CONFIRM_W-1:0];
                REG_SORT_TIME: cfg_next.sort_time      = cfg_data[SORT_W-1:0];
                REG_TICK_MS:   cfg_next.tick_ms        = cfg_data[TICK_W-1:0];
                REG_BLUE_LOW:  cfg_next.blue_hue_low   = cfg_data[HUE_W-1:0];
                REG_BLUE_HIGH: cfg_next.blue_hue_high  = cfg_data[HUE_W-1:0];
                REG_RED_HIGH:  cfg_next.red_hue_high   = cfg_data[HUE_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alliance_color <= RST_ALLIANCE;
            cfg_reg.confirm_time   <= RST_CONFIRM;
            cfg_reg.sort_time      <= RST_SORT_TIME;
            cfg_reg.tick_ms        <= RST_TICK_MS;
            cfg_reg.blue_hue_low   <= RST_BLUE_LOW;
            cfg_reg.blue_hue_high  <= RST_BLUE_HIGH;
            cfg_reg.red_hue_high   <= RST_RED_HIGH;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== src/dhcsp_update.sv =====
// Dwell timers, latched color and sort pulse state with their per-tick update.
module dhcsp_update
    import dhcsp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               fire,
    input  logic [HUE_W-1:0]   hue,
    input  logic               enable,
    output logic [COLOR_W-1:0] detected_color,
    output logic               sorting
);

    logic [DWELL_W-1:0] blue_dwell_reg, blue_dwell_next;
    logic [DWELL_W-1:0] red_dwell_reg, red_dwell_next;
    logic [COLOR_W-1:0] latched_reg, latched_next;
    logic               active_reg, active_next;
    logic [SORT_W-1:0]  elapsed_reg, elapsed_next;

    logic               in_blue;
    logic               in_red;
    logic [DWELL_W-1:0] confirm_ext;
    logic [DWELL_W-1:0] band_dwell;
    logic               band_confirmed;
    logic [DWELL_W-1:0] band_base;
    logic [DWELL_W-1:0] band_sum;
    logic [SORT_W-1:0]  elapsed_base;
    logic [SORT_W:0]    elapsed_sum;

    assign in_blue = (hue > cfg.blue_hue_low) && (hue < cfg.blue_hue_high);
    assign in_red  = (hue < cfg.red_hue_high) && (hue != '0);

    assign confirm_ext    = {{(DWELL_W-CONFIRM_W){1'b0}}, cfg.confirm_time};
    assign band_dwell     = in_blue ? blue_dwell_reg : red_dwell_reg;
    assign band_confirmed = band_dwell >= confirm_ext;
    // Once confirmed the timer is clamped to the confirm time before the tick is added.
    assign band_base      = band_confirmed ? confirm_ext : band_dwell;
    assign band_sum       = band_base + {{(DWELL_W-TICK_W){1'b0}}, cfg.tick_ms};

    always_comb
    begin
        blue_dwell_next = '0;
        red_dwell_next  = '0;
        latched_next    = latched_reg;
        active_next     = active_reg;
        elapsed_next    = elapsed_reg;
        elapsed_base    = elapsed_reg;
        elapsed_sum     = '0;

        if (enable)
        begin
            if (in_blue)
            begin
                blue_dwell_next = band_sum;
                if (band_confirmed)
                    latched_next = COLOR_BLUE;
            end
            else if (in_red)
            begin
                red_dwell_next = band_sum;
                if (band_confirmed)
                    latched_next = COLOR_RED;
            end
            else
            begin
                latched_next = COLOR_NONE;
            end

            if ((latched_next != cfg.alliance_color) && (cfg.alliance_color != COLOR_NONE)
                && (latched_next != COLOR_NONE))
                active_next = 1'b1;

            // The pulse ends with elapsed cleared, yet the tick is still added after it.
            if (active_next)
            begin
                if (elapsed_reg >= cfg.sort_time)
                begin
                    active_next  = 1'b0;
                    elapsed_base = '0;
                end
                elapsed_sum  = {1'b0, elapsed_base} + {{(SORT_W+1-TICK_W){1'b0}}, cfg.tick_ms};
                elapsed_next = elapsed_sum[SORT_W] ? '1 : elapsed_sum[SORT_W-1:0];
            end
        end
        else
        begin
            latched_next = COLOR_NONE;
            active_next  = 1'b0;
            elapsed_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blue_dwell_reg <= '0;
            red_dwell_reg  <= '0;
            latched_reg    <= COLOR_NONE;
            active_reg     <= 1'b0;
            elapsed_reg    <= '0;
        end
        else if (fire)
        begin
            blue_dwell_reg <= blue_dwell_next;
            red_dwell_reg  <= red_dwell_next;
            latched_reg    <= latched_next;
            active_reg     <= active_next;
            elapsed_reg    <= elapsed_next;
        end
    end

    assign detected_color = latched_reg;
    assign sorting        = active_reg;

    a_disable_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !enable |=> latched_reg == COLOR_NONE && !active_reg && elapsed_reg == '0)
        else $error("disabled tick left state behind");

    a_one_timer: assert property (@(posedge clk) disable iff (!rst_n)
        !(blue_dwell_reg != '0 && red_dwell_reg != '0))
        else $error("both dwell timers running");

    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(latched_reg) && $stable(active_reg) && $stable(elapsed_reg))
        else $error("state changed without a tick");

endmodule

// ===== src/debounced_hue_classifier_sort_pulse_core.sv =====
// Top level of the debounced hue classifier with wrong-color sort pulse.
//
//   channel  direction  handshake             payload
//   in       to block   in_valid / in_stall   hue, enable
//   out      from block out_valid / out_stall detected_color, sorting
//   cfg      to block   cfg_valid / cfg_ready cfg_index, cfg_data
//
// A word is registered on input, then updated into the state registers, which also
// serve as the result register; one word per cycle while the output is not stalled.
// Reset clears the state to no color and no pulse and loads the default registers.
// A stall on the output holds the result and stalls the input once the input register is full.
module debounced_hue_classifier_sort_pulse_core
    import dhcsp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [HUE_W-1:0]   hue,
    input  logic               enable,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [COLOR_W-1:0] detected_color,
    output logic               sorting,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [DATA_W-1:0]  cfg_data
);

    cfg_t cfg;

    logic             s1_valid_reg, s1_valid_next;
    logic [HUE_W-1:0] s1_hue_reg;
    logic             s1_enable_reg;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;
    logic             fire;
    logic             in_take;

    assign out_free = !out_valid_reg || !out_stall;
    assign fire     = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    assign s1_valid_next  = in_take || (s1_valid_reg && !fire);
    assign out_valid_next = fire || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_hue_reg    <= hue;
            s1_enable_reg <= enable;
        end
    end

    dhcsp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .cfg       (cfg)
    );

    dhcsp_update u_update (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .fire           (fire),
        .hue            (s1_hue_reg),
        .enable         (s1_enable_reg),
        .detected_color (detected_color),
        .sorting        (sorting)
    );

    assign out_valid = out_valid_reg;

    a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with an empty input register");

    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_free |=> s1_valid_reg && $stable(s1_hue_reg)
            && $stable(s1_enable_reg))
        else $error("input word lost while output blocked");

    a_out_drains: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_stall && !s1_valid_reg |=> !out_valid_reg)
        else $error("result repeated after it was taken");

endmodule
